/* hw/rtl/mexp_pkg.sv */
// shared types and constants for the modular exponentiation block
// no dependencies
package mexp_pkg;

	localparam int unsigned WORD_W = 16;
	localparam int unsigned MOD_BITS_DEF = 16;
	localparam int unsigned MM_BITS = 16;
	localparam int unsigned MM_CNT_W = $clog2(MM_BITS);

	localparam logic REG_EXPONENT = 1'b0;
	localparam logic REG_MODULUS = 1'b1;

	localparam logic [WORD_W-1:0] EXPONENT_RST = 16'd0;
	localparam logic [WORD_W-1:0] MODULUS_RST = 16'd23707;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RED,
		ST_MUL,
		ST_OUT
	} state_t;

endpackage

/* hw/rtl/mexp_cell.sv */
// one cell of the multiplier bit chain: holds one operand bit
// and passes it to the next cell each cycle while shift is high; uses no package items
module mexp_cell (
	input  logic clk,
	input  logic load,
	input  logic shift,
	input  logic load_bit,
	input  logic prev_bit,
	output logic bit_q
);

	always_ff @(posedge clk) begin
		if (load) begin
			bit_q <= load_bit;
		end else if (shift) begin
			bit_q <= prev_bit;
		end
	end

endmodule

/* hw/rtl/mexp_modmul.sv */
// interleaved modular multiplier: r = a*b mod n, one bit of b a cycle
// depends on mexp_pkg and mexp_cell
module mexp_modmul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mexp_pkg::WORD_W-1:0] a,
	input  logic [mexp_pkg::WORD_W-1:0] b,
	input  logic [mexp_pkg::WORD_W-1:0] n,
	output logic                        done,
	output logic [mexp_pkg::WORD_W-1:0] r
);

	logic [mexp_pkg::MM_BITS-1:0]  chain;
	logic                          run_q;
	logic                          done_q;
	logic [mexp_pkg::MM_CNT_W-1:0] cnt_q;
	logic [mexp_pkg::WORD_W-1:0]   r_q;
	logic [mexp_pkg::WORD_W+1:0]   t1, t2, t3, nx;

	for (genvar i = 0; i < mexp_pkg::MM_BITS; i++) begin : g_cell
		mexp_cell u_cell (
			.clk      (clk),
			.load     (start),
			.shift    (run_q),
			.load_bit (b[i]),
			.prev_bit ((i == 0) ? 1'b0 : chain[(i == 0) ? 0 : i-1]),
			.bit_q    (chain[i])
		);
	end

	// operands stay below n, so 2r + a < 3n: two subtract steps suffice
	always_comb begin
		nx = {2'b00, n};
		t1 = {1'b0, r_q, 1'b0} + (chain[mexp_pkg::MM_BITS-1] ? {2'b00, a} : '0);
		t2 = (t1 >= nx) ? t1 - nx : t1;
		t3 = (t2 >= nx) ? t2 - nx : t2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == mexp_pkg::MM_CNT_W'(mexp_pkg::MM_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
		end else if (run_q) begin
			r_q <= t3[mexp_pkg::WORD_W-1:0];
		end
	end

	assign done = done_q;
	assign r    = r_q;

endmodule

/* hw/rtl/modular_exponentiation.sv */
// top level: square-and-multiply sequencer over two bit-serial modular multipliers
// a zero exponent or zero modulus goes straight to the output state; otherwise one
// reduction step, then one multiply step per exponent bit up to the highest set bit
// each step: launch, 16 operand bits through the cell chain, handoff
// a new word is taken only when idle; busy high through the done strobe; no stall
// reset: exponent 0, modulus 23707, idle; uses mexp_pkg and mexp_modmul
module modular_exponentiation #(
	parameter int unsigned MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [mexp_pkg::WORD_W-1:0] base_value,
	output logic                        done,
	output logic [mexp_pkg::WORD_W-1:0] power_result,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [mexp_pkg::WORD_W-1:0] cfg_wdata
);

	mexp_pkg::state_t            state_q, state_d;
	logic                        launch_q, launch_d;
	logic [mexp_pkg::WORD_W-1:0] exponent_q, modulus_q;
	logic [mexp_pkg::WORD_W-1:0] exp_q, sq_q, acc_q, base_q, res_q;
	logic [mexp_pkg::WORD_W-1:0] base_m, acc_n;
	logic [mexp_pkg::WORD_W-1:0] u0_a, u0_b, r0, r1;
	logic                        d0, d1;
	logic                        accept;

	assign accept = start && (state_q == mexp_pkg::ST_IDLE);

	always_comb begin
		for (int i = 0; i < mexp_pkg::WORD_W; i++) begin
			base_m[i] = (i < MOD_BITS) ? base_value[i] : 1'b0;
		end
	end

	assign u0_a  = (state_q == mexp_pkg::ST_RED) ? mexp_pkg::WORD_W'(1) : acc_q;
	assign u0_b  = (state_q == mexp_pkg::ST_RED) ? base_q : sq_q;
	assign acc_n = exp_q[0] ? r0 : acc_q;

	mexp_modmul u_mul_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (launch_q),
		.a      (u0_a),
		.b      (u0_b),
		.n      (modulus_q),
		.done   (d0),
		.r      (r0)
	);

	mexp_modmul u_mul_sq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (launch_q),
		.a      (sq_q),
		.b      (sq_q),
		.n      (modulus_q),
		.done   (d1),
		.r      (r1)
	);

	always_comb begin
		state_d  = state_q;
		launch_d = 1'b0;
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (start) begin
					if (exponent_q == '0 || modulus_q == '0) begin
						state_d = mexp_pkg::ST_OUT;
					end else begin
						state_d  = mexp_pkg::ST_RED;
						launch_d = 1'b1;
					end
				end
			end
			mexp_pkg::ST_RED: begin
				if (d0) begin
					state_d  = mexp_pkg::ST_MUL;
					launch_d = 1'b1;
				end
			end
			mexp_pkg::ST_MUL: begin
				if (d0 && d1) begin
					if (exp_q[mexp_pkg::WORD_W-1:1] == '0) begin
						state_d = mexp_pkg::ST_OUT;
					end else begin
						launch_d = 1'b1;
					end
				end
			end
			mexp_pkg::ST_OUT: begin
				state_d = mexp_pkg::ST_IDLE;
			end
			default: begin
				state_d = mexp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mexp_pkg::ST_IDLE;
			launch_q   <= 1'b0;
			exponent_q <= mexp_pkg::EXPONENT_RST;
			modulus_q  <= mexp_pkg::MODULUS_RST;
		end else begin
			state_q  <= state_d;
			launch_q <= launch_d;
			if (cfg_we) begin
				if (cfg_index == mexp_pkg::REG_EXPONENT) begin
					exponent_q <= cfg_wdata;
				end else begin
					modulus_q <= cfg_wdata;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= base_m;
			exp_q  <= exponent_q;
			// zero exponent gives 1 unreduced (also with zero modulus), else zero modulus gives 0
			res_q  <= (exponent_q == '0) ? mexp_pkg::WORD_W'(1) : '0;
		end
		if (state_q == mexp_pkg::ST_RED && d0) begin
			sq_q  <= r0;
			acc_q <= (modulus_q == mexp_pkg::WORD_W'(1)) ? '0 : mexp_pkg::WORD_W'(1);
		end
		if (state_q == mexp_pkg::ST_MUL && d0 && d1) begin
			acc_q <= acc_n;
			sq_q  <= r1;
			exp_q <= exp_q >> 1;
			res_q <= acc_n;
		end
	end

	assign busy         = (state_q != mexp_pkg::ST_IDLE);
	assign done         = (state_q == mexp_pkg::ST_OUT);
	assign power_result = res_q;

endmodule
